### rtl/rigid_polygon_step_with_aabb_top_macros.svh
// assertion macros for the rigid polygon step block
// expects signals named clk and rst_n in the scope of use
`ifndef RIGID_POLYGON_STEP_WITH_AABB_TOP_MACROS_SVH
`define RIGID_POLYGON_STEP_WITH_AABB_TOP_MACROS_SVH

// same-cycle implication, checked outside reset
`define RPS_ASSERT_IMP(lbl, ant, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ant) |-> (cons)) else $error(msg);

// next-cycle implication, checked outside reset
`define RPS_ASSERT_NXT(lbl, ant, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ant) |=> (cons)) else $error(msg);

`endif

### rtl/rps_pkg.sv
// shared types, constants and arithmetic helpers of the rigid polygon step block
// no dependencies
`default_nettype none

package rps_pkg;

  // vertex ring size
  localparam int MAX_V = 16;
  // ring length including the two rotate stages
  localparam int RING_LEN = MAX_V + 2;
  // count at which the bounding box is final
  localparam int FINISH = MAX_V + 4;
  localparam int CNT_W = $clog2(FINISH + 1);
  localparam int NV_W = $clog2(MAX_V + 1);

  // configuration register indexes
  localparam logic [2:0] CFG_VERTEX_COUNT = 3'd0;
  localparam logic [2:0] CFG_VEL_X        = 3'd1;
  localparam logic [2:0] CFG_VEL_Y        = 3'd2;
  localparam logic [2:0] CFG_COS_STEP     = 3'd3;
  localparam logic [2:0] CFG_SIN_STEP     = 3'd4;
  localparam logic [2:0] CFG_START_X      = 3'd5;
  localparam logic [2:0] CFG_START_Y      = 3'd6;

  // input function codes
  localparam logic FUNC_LOAD = 1'b0;
  localparam logic FUNC_TICK = 1'b1;

  // register reset values
  localparam logic [4:0]         VCOUNT_RST = 5'd4;
  localparam logic signed [15:0] COS_RST    = 16'sh7FFF;
  localparam logic [4:0]         VCOUNT_MIN = 5'd3;

  typedef struct packed {
    logic signed [31:0] x;
    logic signed [31:0] y;
  } vertex_t;

  typedef struct packed {
    logic signed [15:0] min_x;
    logic signed [15:0] min_y;
    logic signed [15:0] max_x;
    logic signed [15:0] max_y;
  } box_t;

  // ring shift control toward the rotate unit
  typedef struct packed {
    logic shift;
    logic apply;
  } rot_ctl_t;

  // bounding box accumulator control
  typedef struct packed {
    logic clear;
    logic vld;
  } box_ctl_t;

  // saturate a 34 bit value to signed 32 bits
  function automatic logic signed [31:0] sat32(input logic signed [33:0] v);
    logic signed [31:0] r;
    if (v[33:31] == 3'b000 || v[33:31] == 3'b111) begin
      r = v[31:0];
    end else if (v[33]) begin
      r = 32'sh8000_0000;
    end else begin
      r = 32'sh7FFF_FFFF;
    end
    return r;
  endfunction

  // Q16.16 truncated toward zero, saturated to signed 16 bits
  function automatic logic signed [15:0] trunc16(input logic signed [32:0] s);
    logic signed [32:0] t;
    logic signed [16:0] q;
    logic signed [15:0] r;
    t = s + (s[32] ? 33'sh0_0000_FFFF : 33'sh0);
    q = t[32:16];
    if (q[16] == q[15]) begin
      r = q[15:0];
    end else if (q[16]) begin
      r = 16'sh8000;
    end else begin
      r = 16'sh7FFF;
    end
    return r;
  endfunction

endpackage

`default_nettype wire

### rtl/rps_in_if.sv
// input channel of the rigid polygon step block: valid/ready plus one item
// no dependencies
`default_nettype none

interface rps_in_if;
  logic               valid;
  logic               ready;
  logic               func;
  logic [3:0]         vertex_index;
  logic signed [31:0] offset_x;
  logic signed [31:0] offset_y;

  modport source (output valid, func, vertex_index, offset_x, offset_y, input ready);
  modport sink (input valid, func, vertex_index, offset_x, offset_y, output ready);
endinterface

`default_nettype wire

### rtl/rps_out_if.sv
// result channel of the rigid polygon step block: valid/ready plus one result
// no dependencies
`default_nettype none

interface rps_out_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] box_min_x;
  logic signed [15:0] box_min_y;
  logic signed [15:0] box_max_x;
  logic signed [15:0] box_max_y;
  logic signed [31:0] center_x;
  logic signed [31:0] center_y;

  modport source (output valid, box_min_x, box_min_y, box_max_x, box_max_y,
                  center_x, center_y, input ready);
  modport sink (input valid, box_min_x, box_min_y, box_max_x, box_max_y,
                center_x, center_y, output ready);
endinterface

`default_nettype wire

### rtl/rps_cell.sv
// one vertex cell of the ring: holds an offset pair, loads or shifts from its neighbor
// depends on rps_pkg
`default_nettype none

module rps_cell (
  input  wire logic            clk,
  input  wire logic            shift_en,
  input  wire rps_pkg::vertex_t shift_in,
  input  wire logic            load_en,
  input  wire rps_pkg::vertex_t load_val,
  output rps_pkg::vertex_t     val
);

  rps_pkg::vertex_t val_r;

  // direct load when idle, neighbor shift during a tick
  always_ff @(posedge clk) begin
    if (load_en) begin
      val_r <= load_val;
    end else if (shift_en) begin
      val_r <= shift_in;
    end
  end

  assign val = val_r;

endmodule

`default_nettype wire

### rtl/rps_rot.sv
// two-stage rotate unit closing the vertex ring: products, then round and saturate
// depends on rps_pkg
`default_nettype none

module rps_rot (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire rps_pkg::rot_ctl_t  ctl,
  input  wire logic signed [15:0] cos_step,
  input  wire logic signed [15:0] sin_step,
  input  wire rps_pkg::vertex_t   vin,
  output rps_pkg::vertex_t        vout,
  output logic                    new_vld
);

  rps_pkg::vertex_t   raw_r;
  logic               apply_r;
  logic signed [47:0] pcx_r, psy_r, psx_r, pcy_r;
  logic signed [47:0] pcx_nxt, psy_nxt, psx_nxt, pcy_nxt;
  logic signed [48:0] sum_x, sum_y;
  rps_pkg::vertex_t   rot_val;
  rps_pkg::vertex_t   vout_r;
  logic               new_vld_r;

  // stage one: the four products
  assign pcx_nxt = cos_step * vin.x;
  assign psy_nxt = sin_step * vin.y;
  assign psx_nxt = sin_step * vin.x;
  assign pcy_nxt = cos_step * vin.y;

  always_ff @(posedge clk) begin
    if (ctl.shift) begin
      raw_r <= vin;
      pcx_r <= pcx_nxt;
      psy_r <= psy_nxt;
      psx_r <= psx_nxt;
      pcy_r <= pcy_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      apply_r   <= 1'b0;
      new_vld_r <= 1'b0;
    end else begin
      if (ctl.shift) begin
        apply_r <= ctl.apply;
      end
      new_vld_r <= ctl.shift & apply_r;
    end
  end

  // stage two: round half up, floor shift, saturate
  assign sum_x = 49'(pcx_r) - 49'(psy_r) + 49'sd16384;
  assign sum_y = 49'(psx_r) + 49'(pcy_r) + 49'sd16384;
  assign rot_val.x = rps_pkg::sat32(sum_x[48:15]);
  assign rot_val.y = rps_pkg::sat32(sum_y[48:15]);

  // entries outside the active count pass unchanged
  always_ff @(posedge clk) begin
    if (ctl.shift) begin
      vout_r <= apply_r ? rot_val : raw_r;
    end
  end

  assign vout    = vout_r;
  assign new_vld = new_vld_r;

endmodule

`default_nettype wire

### rtl/rps_box.sv
// bounding box path: center add, integer truncation, running min and max
// depends on rps_pkg
`default_nettype none

module rps_box (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire rps_pkg::box_ctl_t ctl,
  input  wire rps_pkg::vertex_t  center,
  input  wire rps_pkg::vertex_t  vin,
  output rps_pkg::box_t          box
);

  logic               b1_vld_r;
  logic signed [32:0] sum_x_r, sum_y_r;
  logic               b2_vld_r;
  logic signed [15:0] bx_r, by_r;
  rps_pkg::box_t      acc_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b1_vld_r <= 1'b0;
      b2_vld_r <= 1'b0;
    end else begin
      b1_vld_r <= ctl.vld;
      b2_vld_r <= b1_vld_r;
    end
  end

  // absolute vertex position, exact 33 bits
  always_ff @(posedge clk) begin
    if (ctl.vld) begin
      sum_x_r <= 33'(center.x) + 33'(vin.x);
      sum_y_r <= 33'(center.y) + 33'(vin.y);
    end
  end

  // truncate to integer
  always_ff @(posedge clk) begin
    if (b1_vld_r) begin
      bx_r <= rps_pkg::trunc16(sum_x_r);
      by_r <= rps_pkg::trunc16(sum_y_r);
    end
  end

  // running extremes, reopened at each tick
  always_ff @(posedge clk) begin
    if (!rst_n || ctl.clear) begin
      acc_r.min_x <= 16'sh7FFF;
      acc_r.min_y <= 16'sh7FFF;
      acc_r.max_x <= 16'sh8000;
      acc_r.max_y <= 16'sh8000;
    end else if (b2_vld_r) begin
      if (bx_r < acc_r.min_x) acc_r.min_x <= bx_r;
      if (by_r < acc_r.min_y) acc_r.min_y <= by_r;
      if (bx_r > acc_r.max_x) acc_r.max_x <= bx_r;
      if (by_r > acc_r.max_y) acc_r.max_y <= by_r;
    end
  end

  assign box = acc_r;

endmodule

`default_nettype wire

### rtl/rigid_polygon_step_with_aabb_top.sv
// Rigid polygon step with bounding box, top level.
// Channels: in_ch takes transactions of func, vertex_index, offset_x, offset_y;
// out_ch returns box_min/max x/y and the new center; cfg_we/cfg_index/cfg_data
// write the seven registers (vertex count, velocity, cos/sin step, start point).
// A load transaction (func 0) writes one vertex cell in its accept cycle, gives
// no result, and a load of vertex 0 also copies the start point into the center.
// Loads are taken one per cycle while no tick is in flight.
// A tick transaction (func 1) turns the vertex ring once: all MAX_V cells shift
// through the two-stage rotate unit, one vertex per cycle, and the box path adds
// its sum and truncation registers. The result is presented once the box is final,
// and the next input transaction is taken once the result has moved into the
// output register.
// A finished result waits in the output register while out_ch.ready is low;
// loads and a further tick are still accepted meanwhile, and that tick holds
// at its end until the output register is free.
// Reset (rst_n low, synchronous) clears the center, the control and the registers
// to their defaults; vertex cells are undefined until loaded.
// depends on rps_pkg, rps_in_if, rps_out_if, rps_cell, rps_rot, rps_box and the macros header
`default_nettype none

`include "rigid_polygon_step_with_aabb_top_macros.svh"

module rigid_polygon_step_with_aabb_top (
  input  wire logic        clk,
  input  wire logic        rst_n,
  rps_in_if.sink           in_ch,
  rps_out_if.source        out_ch,
  input  wire logic        cfg_we,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [31:0] cfg_data
);

  localparam int MAX_V = rps_pkg::MAX_V;
  localparam int CNT_W = rps_pkg::CNT_W;
  localparam int NV_W  = rps_pkg::NV_W;

  // configuration registers
  logic [4:0]         vcount_r;
  logic signed [31:0] vel_x_r, vel_y_r;
  logic signed [15:0] cos_r, sin_r;
  logic signed [31:0] start_x_r, start_y_r;

  // control and center
  logic               busy_r;
  logic [CNT_W-1:0]   cnt_r;
  rps_pkg::vertex_t   center_r;
  logic               out_valid_r;
  rps_pkg::box_t      out_box_r;
  rps_pkg::vertex_t   out_center_r;

  logic               in_fire, load_fire, tick_fire, load_ok;
  logic               finish, out_load;
  logic [NV_W-1:0]    n_eff;
  logic [CNT_W-1:0]   apply_lo;
  rps_pkg::rot_ctl_t  rot_ctl;
  rps_pkg::box_ctl_t  box_ctl;
  rps_pkg::vertex_t   load_val;
  rps_pkg::vertex_t   cell_val [MAX_V];
  rps_pkg::vertex_t   rot_out;
  logic               rot_new;
  rps_pkg::box_t      box_acc;

  // configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vcount_r  <= rps_pkg::VCOUNT_RST;
      vel_x_r   <= '0;
      vel_y_r   <= '0;
      cos_r     <= rps_pkg::COS_RST;
      sin_r     <= '0;
      start_x_r <= '0;
      start_y_r <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        rps_pkg::CFG_VERTEX_COUNT: vcount_r  <= cfg_data[4:0];
        rps_pkg::CFG_VEL_X:        vel_x_r   <= cfg_data;
        rps_pkg::CFG_VEL_Y:        vel_y_r   <= cfg_data;
        rps_pkg::CFG_COS_STEP:     cos_r     <= cfg_data[15:0];
        rps_pkg::CFG_SIN_STEP:     sin_r     <= cfg_data[15:0];
        rps_pkg::CFG_START_X:      start_x_r <= cfg_data;
        rps_pkg::CFG_START_Y:      start_y_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // clamp the vertex count into its working range
  always_comb begin
    if (vcount_r < rps_pkg::VCOUNT_MIN) begin
      n_eff = NV_W'(rps_pkg::VCOUNT_MIN);
    end else if (int'(vcount_r) > MAX_V) begin
      n_eff = NV_W'(MAX_V);
    end else begin
      n_eff = NV_W'(vcount_r);
    end
  end

  // input handshake
  assign in_ch.ready = !busy_r;
  assign in_fire     = in_ch.valid && in_ch.ready;
  assign load_fire   = in_fire && (in_ch.func == rps_pkg::FUNC_LOAD);
  assign tick_fire   = in_fire && (in_ch.func == rps_pkg::FUNC_TICK);
  assign load_ok     = load_fire && (int'(in_ch.vertex_index) < MAX_V);

  assign finish   = busy_r && (cnt_r == CNT_W'(rps_pkg::FINISH));
  assign out_load = finish && (!out_valid_r || out_ch.ready);

  // tick sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else if (tick_fire) begin
      busy_r <= 1'b1;
      cnt_r  <= '0;
    end else if (busy_r) begin
      if (!finish) begin
        cnt_r <= cnt_r + CNT_W'(1);
      end else if (out_load) begin
        busy_r <= 1'b0;
      end
    end
  end

  // center: start point on vertex 0 load, velocity step on tick
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      center_r <= '0;
    end else if (tick_fire) begin
      center_r.x <= center_r.x + vel_x_r;
      center_r.y <= center_r.y + vel_y_r;
    end else if (load_ok && (in_ch.vertex_index == '0)) begin
      center_r.x <= start_x_r;
      center_r.y <= start_y_r;
    end
  end

  // the cell leaving the ring at step k holds vertex MAX_V-1-k
  assign apply_lo      = CNT_W'(MAX_V) - CNT_W'(n_eff);
  assign rot_ctl.shift = busy_r && (cnt_r < CNT_W'(rps_pkg::RING_LEN));
  assign rot_ctl.apply = (cnt_r < CNT_W'(MAX_V)) && (cnt_r >= apply_lo);

  assign load_val.x = in_ch.offset_x;
  assign load_val.y = in_ch.offset_y;

  // vertex ring
  for (genvar i = 0; i < MAX_V; i++) begin : g_cell
    rps_cell u_cell (
      .clk      (clk),
      .shift_en (rot_ctl.shift),
      .shift_in ((i == 0) ? rot_out : cell_val[(i == 0) ? 0 : i - 1]),
      .load_en  (load_ok && (int'(in_ch.vertex_index) == i)),
      .load_val (load_val),
      .val      (cell_val[i])
    );
  end

  rps_rot u_rot (
    .clk      (clk),
    .rst_n    (rst_n),
    .ctl      (rot_ctl),
    .cos_step (cos_r),
    .sin_step (sin_r),
    .vin      (cell_val[MAX_V-1]),
    .vout     (rot_out),
    .new_vld  (rot_new)
  );

  assign box_ctl.clear = tick_fire;
  assign box_ctl.vld   = rot_new;

  rps_box u_box (
    .clk    (clk),
    .rst_n  (rst_n),
    .ctl    (box_ctl),
    .center (center_r),
    .vin    (rot_out),
    .box    (box_acc)
  );

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_box_r    <= box_acc;
      out_center_r <= center_r;
    end
  end

  assign out_ch.valid     = out_valid_r;
  assign out_ch.box_min_x = out_box_r.min_x;
  assign out_ch.box_min_y = out_box_r.min_y;
  assign out_ch.box_max_x = out_box_r.max_x;
  assign out_ch.box_max_y = out_box_r.max_y;
  assign out_ch.center_x  = out_center_r.x;
  assign out_ch.center_y  = out_center_r.y;

  // checks
  `RPS_ASSERT_NXT(a_tick_starts, tick_fire, busy_r && (cnt_r == '0), "tick did not start the ring")
  `RPS_ASSERT_IMP(a_no_late_sample, finish, !rot_new, "vertex sample after the box was final")
  `RPS_ASSERT_IMP(a_idle_ring, !busy_r, !rot_ctl.shift, "ring shifted while idle")
  `RPS_ASSERT_IMP(a_out_from_finish, $rose(out_valid_r),
                  $past(busy_r) && ($past(cnt_r) == CNT_W'(rps_pkg::FINISH)),
                  "result raised outside tick finish")

endmodule

`default_nettype wire
